### design/ipdx_pkg.sv
`default_nettype none

package ipdx_pkg;

   // frame limits
   localparam int PAYLOAD_LIMIT = 1023;
   localparam int META_CHARS    = 19;

   // derived widths
   localparam int LEN_W = $clog2(PAYLOAD_LIMIT + 1);
   localparam int HDR_W = $clog2(META_CHARS + 1);
   localparam int ID_W  = 16;
   localparam int ACC_W = (LEN_W > ID_W) ? LEN_W : ID_W;

   // magnitude cap of the connection id before the sign is applied
   localparam int ID_MAG_CAP = 32768;

   // character codes
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_I     = 8'h49;
   localparam logic [7:0] CH_P     = 8'h50;
   localparam logic [7:0] CH_D     = 8'h44;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;

   // number decode phases
   localparam logic [1:0] DEC_WS  = 2'd0;
   localparam logic [1:0] DEC_POS = 2'd1;
   localparam logic [1:0] DEC_NEG = 2'd2;
   localparam logic [1:0] DEC_END = 2'd3;

   typedef struct packed {
      logic [1:0]       phase;
      logic [ACC_W-1:0] acc;
   } dec_type;

   typedef struct packed {
      logic signed [15:0] conn_id;
      logic [7:0]         payload_byte;
      logic [9:0]         byte_index;
      logic [9:0]         frame_length;
      logic               last_byte;
   } rsp_type;

   // one character of a decimal number with leading whitespace and optional sign,
   // magnitude saturating at cap
   function automatic dec_type dec_step(input dec_type cur, input logic [7:0] b,
                                        input logic [ACC_W-1:0] cap);
      dec_type          nxt;
      logic             digit;
      logic             ws;
      logic [ACC_W+3:0] v;
      logic [ACC_W+3:0] capx;
      logic [ACC_W-1:0] sat;
      nxt   = cur;
      digit = (b >= CH_ZERO) && (b <= CH_NINE);
      ws    = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
      // acc * 10 + digit
      v     = ((ACC_W+4)'(cur.acc) << 3) + ((ACC_W+4)'(cur.acc) << 1)
            + (ACC_W+4)'(b - CH_ZERO);
      capx  = (ACC_W+4)'(cap);
      sat   = (v > capx) ? cap : ACC_W'(v);
      unique case (cur.phase) inside
         DEC_WS: begin
            if (ws) begin
               nxt = cur;
            end else if (b == CH_PLUS) begin
               nxt.phase = DEC_POS;
            end else if (b == CH_MINUS) begin
               nxt.phase = DEC_NEG;
            end else if (digit) begin
               nxt.acc   = sat;
               nxt.phase = DEC_POS;
            end else begin
               nxt.phase = DEC_END;
            end
         end
         DEC_POS, DEC_NEG: begin
            if (digit) begin
               nxt.acc = sat;
            end else begin
               nxt.phase = DEC_END;
            end
         end
         default: begin
            nxt = cur;
         end
      endcase
      return nxt;
   endfunction

endpackage

`default_nettype wire

### design/ipdx_in_stage.sv
`default_nettype none

module ipdx_in_stage
   import ipdx_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_rx_byte,
   output logic            byte_valid_o,
   output logic [7:0]      byte_o,
   input  wire logic       byte_taken_i
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;

   assign req_ready    = !valid_ff || byte_taken_i;
   assign byte_valid_o = valid_ff;
   assign byte_o       = byte_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (byte_taken_i) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff <= req_rx_byte;
      end
   end

endmodule

`default_nettype wire

### design/ipdx_parser.sv
`default_nettype none

module ipdx_parser
   import ipdx_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       byte_valid_i,
   input  wire logic [7:0] byte_i,
   output logic            byte_taken_o,
   input  wire logic       out_room_i,
   output logic            rsp_load_o,
   output rsp_type         rsp_o
);

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_PLUS = 3'd1;
   localparam logic [2:0] PH_I    = 3'd2;
   localparam logic [2:0] PH_P    = 3'd3;
   localparam logic [2:0] PH_D    = 3'd4;
   localparam logic [2:0] PH_META = 3'd5;
   localparam logic [2:0] PH_DATA = 3'd6;

   logic [2:0]       phase_ff,   phase_in;
   logic [HDR_W-1:0] hdr_cnt_ff, hdr_cnt_in;
   logic             comma_ff,   comma_in;
   logic [ID_W-1:0]  id_acc_ff,  id_acc_in;
   logic [1:0]       id_ph_ff,   id_ph_in;
   logic [LEN_W-1:0] len_acc_ff, len_acc_in;
   logic [1:0]       len_ph_ff,  len_ph_in;
   logic [15:0]      conn_ff,    conn_in;
   logic [LEN_W-1:0] flen_ff,    flen_in;
   logic [LEN_W-1:0] pcnt_ff,    pcnt_in;

   logic    in_data;
   logic    take;
   logic    last;
   dec_type id_dec;
   dec_type len_dec;

   assign in_data      = (phase_ff == PH_DATA);
   assign take         = byte_valid_i && (!in_data || out_room_i);
   assign byte_taken_o = take;
   assign rsp_load_o   = take && in_data;
   assign last         = ((LEN_W+1)'(pcnt_ff) + (LEN_W+1)'(1)) >= (LEN_W+1)'(flen_ff);

   assign id_dec  = dec_step('{phase: id_ph_ff, acc: ACC_W'(id_acc_ff)}, byte_i,
                             ACC_W'(ID_MAG_CAP));
   assign len_dec = dec_step('{phase: len_ph_ff, acc: ACC_W'(len_acc_ff)}, byte_i,
                             ACC_W'(PAYLOAD_LIMIT));

   always_comb begin
      rsp_o.conn_id      = conn_ff;
      rsp_o.payload_byte = byte_i;
      rsp_o.byte_index   = 10'(pcnt_ff);
      rsp_o.frame_length = 10'(flen_ff);
      rsp_o.last_byte    = last;
   end

   always_comb begin
      phase_in   = phase_ff;
      hdr_cnt_in = hdr_cnt_ff;
      comma_in   = comma_ff;
      id_acc_in  = id_acc_ff;
      id_ph_in   = id_ph_ff;
      len_acc_in = len_acc_ff;
      len_ph_in  = len_ph_ff;
      conn_in    = conn_ff;
      flen_in    = flen_ff;
      pcnt_in    = pcnt_ff;
      if (take) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (byte_i == CH_PLUS) begin
                  phase_in = PH_PLUS;
               end
            end
            PH_PLUS: begin
               phase_in = (byte_i == CH_I) ? PH_I : PH_IDLE;
            end
            PH_I: begin
               phase_in = (byte_i == CH_P) ? PH_P : PH_IDLE;
            end
            PH_P: begin
               phase_in = (byte_i == CH_D) ? PH_D : PH_IDLE;
            end
            PH_D: begin
               if (byte_i == CH_COMMA) begin
                  phase_in   = PH_META;
                  hdr_cnt_in = '0;
                  comma_in   = 1'b0;
                  id_acc_in  = '0;
                  id_ph_in   = DEC_WS;
                  len_acc_in = '0;
                  len_ph_in  = DEC_WS;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
            PH_META: begin
               if (byte_i == CH_COLON) begin
                  if (!comma_ff) begin
                     phase_in = PH_IDLE;
                  end else begin
                     // sign applied after saturation of the magnitude
                     if (id_ph_ff == DEC_NEG) begin
                        conn_in = 16'(~id_acc_ff + 16'd1);
                     end else if (id_acc_ff > 16'h7FFF) begin
                        conn_in = 16'h7FFF;
                     end else begin
                        conn_in = id_acc_ff;
                     end
                     // zero, negative or empty length gives one byte
                     if ((len_ph_ff == DEC_NEG) || (len_acc_ff == '0)) begin
                        flen_in = LEN_W'(1);
                     end else begin
                        flen_in = len_acc_ff;
                     end
                     pcnt_in  = '0;
                     phase_in = PH_DATA;
                  end
               end else if (hdr_cnt_ff < HDR_W'(META_CHARS)) begin
                  hdr_cnt_in = hdr_cnt_ff + HDR_W'(1);
                  if (!comma_ff) begin
                     if (byte_i == CH_COMMA) begin
                        comma_in = 1'b1;
                     end else begin
                        id_acc_in = ID_W'(id_dec.acc);
                        id_ph_in  = id_dec.phase;
                     end
                  end else begin
                     len_acc_in = LEN_W'(len_dec.acc);
                     len_ph_in  = len_dec.phase;
                  end
               end
            end
            PH_DATA: begin
               if (last) begin
                  phase_in = PH_IDLE;
                  pcnt_in  = '0;
               end else begin
                  pcnt_in = pcnt_ff + LEN_W'(1);
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         hdr_cnt_ff <= '0;
         comma_ff   <= 1'b0;
         id_acc_ff  <= '0;
         id_ph_ff   <= DEC_WS;
         len_acc_ff <= '0;
         len_ph_ff  <= DEC_WS;
         conn_ff    <= 16'hFFFF;
         flen_ff    <= '0;
         pcnt_ff    <= '0;
      end else begin
         phase_ff   <= phase_in;
         hdr_cnt_ff <= hdr_cnt_in;
         comma_ff   <= comma_in;
         id_acc_ff  <= id_acc_in;
         id_ph_ff   <= id_ph_in;
         len_acc_ff <= len_acc_in;
         len_ph_ff  <= len_ph_in;
         conn_ff    <= conn_in;
         flen_ff    <= flen_in;
         pcnt_ff    <= pcnt_in;
      end
   end

   a_data_count_in_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (pcnt_ff < flen_ff))
      else $error("payload count reached frame length");

   a_load_only_in_data: assert property (@(posedge clock) disable iff (reset)
      rsp_load_o |-> ((phase_ff == PH_DATA) && out_room_i))
      else $error("result loaded outside payload phase or without room");

   a_last_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_load_o && last) |=> (phase_ff == PH_IDLE) && (pcnt_ff == '0))
      else $error("parser did not return to idle after last byte");

   a_header_count_bound: assert property (@(posedge clock) disable iff (reset)
      hdr_cnt_ff <= HDR_W'(META_CHARS))
      else $error("header count past limit");

endmodule

`default_nettype wire

### design/ipdx_out_stage.sv
`default_nettype none

module ipdx_out_stage
   import ipdx_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          load_i,
   input  wire rsp_type       rsp_i,
   output logic               room_o,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic signed [15:0] rsp_conn_id,
   output logic [7:0]         rsp_payload_byte,
   output logic [9:0]         rsp_byte_index,
   output logic [9:0]         rsp_frame_length,
   output logic               rsp_last_byte
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type rsp_ff;

   assign room_o           = !valid_ff || rsp_ready;
   assign rsp_valid        = valid_ff;
   assign rsp_conn_id      = rsp_ff.conn_id;
   assign rsp_payload_byte = rsp_ff.payload_byte;
   assign rsp_byte_index   = rsp_ff.byte_index;
   assign rsp_frame_length = rsp_ff.frame_length;
   assign rsp_last_byte    = rsp_ff.last_byte;

   always_comb begin
      valid_in = valid_ff;
      if (load_i) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_i) begin
         rsp_ff <= rsp_i;
      end
   end

endmodule

`default_nettype wire

### design/at_ipd_frame_extractor.sv
`default_nettype none

// channel   direction  handshake              payload
// req       in         req_valid / req_ready  req_rx_byte
// rsp       out        rsp_valid / rsp_ready  rsp_conn_id, rsp_payload_byte, rsp_byte_index,
//                                             rsp_frame_length, rsp_last_byte
//
// one request per cycle sustained while payload bytes find room; header and marker bytes give no response
// a payload byte shows on rsp from the result register: the input register loads it on the accept edge,
// then the parser update loads it into the result register once that register has room
// the parser update is combinational logic into its state registers: marker match, header
// decode step (acc * 10 + digit with saturation) and payload count
// synchronous active-high reset returns to hunting for the marker, no sweep needed
// rsp stalls hold the result register; header bytes keep flowing while a result
// waits, payload bytes wait for room

module at_ipd_frame_extractor
   import ipdx_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire logic [7:0]    req_rx_byte,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic signed [15:0] rsp_conn_id,
   output logic [7:0]         rsp_payload_byte,
   output logic [9:0]         rsp_byte_index,
   output logic [9:0]         rsp_frame_length,
   output logic               rsp_last_byte
);

   // registered request byte
   logic       byte_valid;
   logic [7:0] byte_q;
   logic       byte_taken;

   // parser to result register
   logic    out_room;
   logic    rsp_load;
   rsp_type rsp_next;

   ipdx_in_stage u_in_stage (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_rx_byte  (req_rx_byte),
      .byte_valid_o (byte_valid),
      .byte_o       (byte_q),
      .byte_taken_i (byte_taken)
   );

   // marker hunt, header decode and payload tagging
   ipdx_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .byte_valid_i (byte_valid),
      .byte_i       (byte_q),
      .byte_taken_o (byte_taken),
      .out_room_i   (out_room),
      .rsp_load_o   (rsp_load),
      .rsp_o        (rsp_next)
   );

   ipdx_out_stage u_out_stage (
      .clock            (clock),
      .reset            (reset),
      .load_i           (rsp_load),
      .rsp_i            (rsp_next),
      .room_o           (out_room),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_conn_id      (rsp_conn_id),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_frame_length (rsp_frame_length),
      .rsp_last_byte    (rsp_last_byte)
   );

endmodule

`default_nettype wire
